FILE: rtl/ple_pkg.sv
package ple_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Field widths of the two channels
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int MIDX_W   = 4;
  localparam int MCNT_W   = 5;
  localparam int LEN_W    = 5;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD    = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_COMPARE = 3'd3,
    CMD_SHIFT   = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [POS_W-1:0]   pos;
  } cell_ctl_t;

endpackage

FILE: rtl/ple_if.sv
interface ple_in_if;
  import ple_pkg::*;

  logic                       valid;
  logic                       ready;
  op_t                        op;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface ple_out_if;
  import ple_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [MIDX_W-1:0]    match_index;
  logic [MCNT_W-1:0]    match_count;
  logic [LEN_W-1:0]     list_length;
  logic                 last;

  modport source (
    output valid, output status, output match_index, output match_count,
    output list_length, output last, input ready
  );
  modport sink (
    input valid, input status, input match_index, input match_count,
    input list_length, input last, output ready
  );
endinterface

FILE: rtl/positional_list_engine.sv
// Ordered list of up to DEPTH values held in a chain of cells.
// in_if carries one request (op, value, position); out_if returns results,
// both with valid/ready, an item moving when both are high.
// Insert and delete move the chain when in range; clear only resets the
// length. One result appears in the output register the cycle after the
// request is accepted. Find: the cells compare against the key, then the
// match flags are shifted toward cell 0 across the list to count them,
// compared again, and shifted once more, one index per cycle while the
// output register is free, emitting one result per match (last set on the
// final one) or a single no-match result.
// One request is worked on at a time; a new one is taken while a result waits
// only if the output register frees in the same cycle.
// Reset (synchronous, rst_n low) empties the list and drops any pending
// result; cell contents are not cleared.
// When the receiver stalls, the result holds in the output register and the
// find scan pauses at the next match until the register is taken.
module positional_list_engine #(
  parameter int DEPTH      = ple_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ple_in_if.sink   in_if,
  ple_out_if.source out_if
);
  import ple_pkg::*;

  localparam int LW   = $clog2(DEPTH + 1);
  localparam int CMPW = (LW > POS_W) ? LW : POS_W;
  localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_COUNT = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  logic [LW-1:0]          idx_r, idx_nxt;
  logic [LW-1:0]          cnt_r, cnt_nxt;
  logic [LW-1:0]          seen_r, seen_nxt;
  logic [VALUE_BITS-1:0]  key_r, key_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [MIDX_W-1:0]      out_midx_r, out_midx_nxt;
  logic [MCNT_W-1:0]      out_mcnt_r, out_mcnt_nxt;
  logic [LEN_W-1:0]       out_len_r, out_len_nxt;
  logic                   out_last_r, out_last_nxt;

  cell_ctl_t              ctl;
  logic [VALUE_BITS-1:0]  cell_data;
  logic [VALUE_BITS-1:0]  in_val;
  logic [VALUE_BITS-1:0]  val_w   [DEPTH];
  logic                   match_w [DEPTH];
  logic                   slot_free;
  logic                   accept;
  logic [CMPW-1:0]        pos_c;
  logic [CMPW-1:0]        len_c;
  logic                   is_last;

  assign in_val    = VALUE_BITS'(unsigned'(in_if.value));
  assign slot_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && slot_free;
  assign accept    = in_if.valid && in_if.ready;
  assign pos_c     = CMPW'(in_if.position);
  assign len_c     = CMPW'(len_r);
  assign is_last   = ((seen_r + LW'(1)) == cnt_r);

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v, right_v;
    logic                  right_m;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = val_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_v = '0;
      assign right_m = 1'b0;
    end else begin : g_mid_r
      assign right_v = val_w[i+1];
      assign right_m = match_w[i+1];
    end
    ple_cell #(
      .VALUE_BITS (VALUE_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .data        (cell_data),
      .left_val    (left_v),
      .right_val   (right_v),
      .right_match (right_m),
      .val         (val_w[i]),
      .match       (match_w[i])
    );
  end

  // Sequence requests and the two find passes
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    seen_nxt       = seen_r;
    key_nxt        = key_r;
    ctl.cmd        = CMD_HOLD;
    ctl.pos        = in_if.position;
    cell_data      = (state_r == S_IDLE) ? in_val : key_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_midx_nxt   = out_midx_r;
    out_mcnt_nxt   = out_mcnt_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_midx_nxt = '0;
          out_mcnt_nxt = '0;
          out_last_nxt = 1'b1;
          unique case (in_if.op)
            OP_INSERT: begin
              if (len_r == FULL_LEN) begin
                out_status_nxt = ST_FULL;
              end else if (pos_c > len_c) begin
                out_status_nxt = ST_RANGE;
              end else begin
                ctl.cmd        = CMD_INSERT;
                len_nxt        = len_r + LW'(1);
                out_status_nxt = ST_OK;
              end
              out_valid_nxt = 1'b1;
            end
            OP_DELETE: begin
              if (pos_c >= len_c) begin
                out_status_nxt = ST_RANGE;
              end else begin
                ctl.cmd        = CMD_DELETE;
                len_nxt        = len_r - LW'(1);
                out_status_nxt = ST_OK;
              end
              out_valid_nxt = 1'b1;
            end
            OP_FIND: begin
              ctl.cmd   = CMD_COMPARE;
              key_nxt   = in_val;
              idx_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_COUNT;
            end
            OP_CLEAR: begin
              len_nxt        = '0;
              out_status_nxt = ST_OK;
              out_valid_nxt  = 1'b1;
            end
            default: ;
          endcase
          out_len_nxt = LEN_W'(len_nxt);
        end
      end
      S_COUNT: begin
        if (idx_r < len_r) begin
          // count the flag at cell 0, advance the chain
          ctl.cmd = CMD_SHIFT;
          cnt_nxt = cnt_r + LW'(match_w[0]);
          idx_nxt = idx_r + LW'(1);
        end else if (cnt_r == '0) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NO_MATCH;
            out_midx_nxt   = '0;
            out_mcnt_nxt   = '0;
            out_len_nxt    = LEN_W'(len_r);
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          // reload the flags for the emit pass
          ctl.cmd   = CMD_COMPARE;
          idx_nxt   = '0;
          seen_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (match_w[0]) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_midx_nxt   = MIDX_W'(idx_r);
            out_mcnt_nxt   = MCNT_W'(cnt_r);
            out_len_nxt    = LEN_W'(len_r);
            out_last_nxt   = is_last;
            ctl.cmd        = CMD_SHIFT;
            idx_nxt        = idx_r + LW'(1);
            seen_nxt       = seen_r + LW'(1);
            if (is_last) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          ctl.cmd = CMD_SHIFT;
          idx_nxt = idx_r + LW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan counters, key and result payload
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    seen_r       <= seen_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_midx_r   <= out_midx_nxt;
    out_mcnt_r   <= out_mcnt_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.match_index = out_midx_r;
  assign out_if.match_count = out_mcnt_r;
  assign out_if.list_length = out_len_r;
  assign out_if.last        = out_last_r;

endmodule

FILE: rtl/ple_cell.sv
module ple_cell #(
  parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEF,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  ple_pkg::cell_ctl_t     ctl,
  input  logic [VALUE_BITS-1:0]  data,
  input  logic [VALUE_BITS-1:0]  left_val,
  input  logic [VALUE_BITS-1:0]  right_val,
  input  logic                   right_match,
  output logic [VALUE_BITS-1:0]  val,
  output logic                   match
);
  import ple_pkg::*;

  localparam logic [POS_W:0] SLOT = (POS_W + 1)'(INDEX);

  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  match_r, match_nxt;
  logic [POS_W:0]        pos_ext;

  assign pos_ext = {1'b0, ctl.pos};

  // Move entries along the chain, or compare and pass match flags toward cell 0
  always_comb begin
    val_nxt   = val_r;
    match_nxt = match_r;
    unique case (ctl.cmd)
      CMD_HOLD: ;
      CMD_INSERT: begin
        if (SLOT == pos_ext) begin
          val_nxt = data;
        end else if (SLOT > pos_ext) begin
          val_nxt = left_val;
        end
      end
      CMD_DELETE: begin
        if (SLOT >= pos_ext) begin
          val_nxt = right_val;
        end
      end
      CMD_COMPARE: match_nxt = (val_r == data);
      CMD_SHIFT:   match_nxt = right_match;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    match_r <= match_nxt;
  end

  assign val   = val_r;
  assign match = match_r;

endmodule

FILE: rtl/ple_checker.sv
module ple_checker #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input ple_pkg::status_t              out_status,
  input logic [ple_pkg::MIDX_W-1:0]    out_match_index,
  input logic [ple_pkg::MCNT_W-1:0]    out_match_count,
  input logic [ple_pkg::LEN_W-1:0]     out_list_length,
  input logic                          out_last
);
  import ple_pkg::*;

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_last))
    else $error("result dropped or changed while stalled");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Length never exceeds the capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_list_length) <= DEPTH)
    else $error("list length above capacity");

  // Any result with a status other than OK closes its request and reports no index or count
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_match_index == '0
      && out_match_count == '0)
    else $error("error result not final or carries match data");

endmodule

bind positional_list_engine ple_checker #(
  .DEPTH (DEPTH)
) u_ple_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_match_index (out_if.match_index),
  .out_match_count (out_if.match_count),
  .out_list_length (out_if.list_length),
  .out_last        (out_if.last)
);
